### sv/assert_macros.svh
// Assertion macros shared by the clustering engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/kce_pkg.sv
// Package of constants and types for the clustering engine.
package kce_pkg;

	localparam int MAX_POINTS   = 1024;
	localparam int MAX_CLUSTERS = 4;
	localparam int MAX_DIM      = 16;

	localparam int COORD_W = 16;
	localparam int PIDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W   = PIDX_W + 1;
	localparam int CIDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int DIDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int SUM_W   = COORD_W + PIDX_W;
	localparam int SQ_W    = 2 * (COORD_W + 1);
	localparam int ACC_W   = SQ_W + DIDX_W;

	// Configuration register widths.
	localparam int CC_W  = 3;
	localparam int IT_W  = 4;
	localparam int DIM_W = 5;
	localparam int CFG_W = DIM_W;

	localparam logic [CC_W-1:0]  CLUSTER_COUNT_RST   = 3'd4;
	localparam logic [IT_W-1:0]  ITERATION_LIMIT_RST = 4'd10;
	localparam logic [DIM_W-1:0] DIMENSION_RST       = 5'd16;

	localparam logic [1:0] REG_CLUSTER_COUNT   = 2'd0;
	localparam logic [1:0] REG_ITERATION_LIMIT = 2'd1;
	localparam logic [1:0] REG_DIMENSION       = 2'd2;

	localparam int OUT_W       = CIDX_W + DIDX_W + COORD_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

### sv/kce_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module kce_divider
	import kce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, div_q}) : CNT_W'(rem_sh);
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

`include "assert_macros.svh"
	`ASSERT_NEXT(a_start_busy, req.start, busy_q, "divider not busy after start")
	`ASSERT_IMPLIES(a_done_idle, done_q, !busy_q, "divider done while still busy")
	`ASSERT_NEXT(a_final_done, busy_q && !req.start && step_q == STEP_W'(SUM_W - 1), done_q,
		"divider missed its done pulse")

endmodule

### sv/kmeans_cluster_engine.sv
// Top level of the k-means clustering engine: storage, sequencer and distance unit.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  coord in tdata, last_point on tlast
//  m_*       out        m_tvalid / m_tready  cluster, coordinate, value; dropped on tuser
//  cfg_*     in         cfg_we               cluster_count, iteration_limit, dimension
//
// Loading takes one word per cycle; s_tready is high only while points are loaded.
// After the word with tlast the sequencer runs the Lloyd passes through one shared
// subtract, square and accumulate unit: each coordinate distance goes through the point
// and centroid memory reads, the registered multiplier and the accumulator, and the
// centroid of each non-empty cluster is updated through the bit-serial divider. Each
// result word then goes through a centroid memory read and the output register, and
// waits out any stall on m_tready; the output register holds the word until it is taken.
// Reset clears all control state; no clearing pass is needed, since the sum store uses valid
// flags and the assignment store is compared against zero in the first pass of a run.
module kmeans_cluster_engine
	import kce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [COORD_W-1:0]     s_tdata,   // coord
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // cluster_index, coord_index, centroid_value
	output logic                   m_tuser,   // dropped
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int PADDR_W = PIDX_W + DIDX_W;
	localparam int CADDR_W = CIDX_W + DIDX_W;
	localparam int NCEN    = MAX_CLUSTERS * MAX_DIM;

	typedef enum logic [18:0] {
		ST_LOAD     = 19'h00001,
		ST_INIT_RD  = 19'h00002,
		ST_INIT_WR  = 19'h00004,
		ST_IT_START = 19'h00008,
		ST_P_START  = 19'h00010,
		ST_D_RD     = 19'h00020,
		ST_D_MUL    = 19'h00040,
		ST_D_ACC    = 19'h00080,
		ST_ASG      = 19'h00100,
		ST_S_RD     = 19'h00200,
		ST_S_WR     = 19'h00400,
		ST_U_CHK    = 19'h00800,
		ST_U_RD     = 19'h01000,
		ST_U_DIV    = 19'h02000,
		ST_U_WAIT   = 19'h04000,
		ST_IT_END   = 19'h08000,
		ST_E_RD     = 19'h10000,
		ST_E_LD     = 19'h20000,
		ST_E_OUT    = 19'h40000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CC_W-1:0]  cluster_count_q;
	logic [IT_W-1:0]  iteration_limit_q;
	logic [DIM_W-1:0] dimension_q;

	// Loading state.
	logic [CNT_W-1:0]  pc_q;
	logic [DIDX_W-1:0] pos_q;
	logic              ovf_q;

	// Sequencer counters and working registers.
	logic [PIDX_W-1:0] p_q;
	logic [CIDX_W-1:0] c_q;
	logic [DIDX_W-1:0] d_q;
	logic [IT_W-1:0]   it_q;
	logic              first_q;
	logic              changed_q;
	logic [SQ_W-1:0]   sq_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  best_q;
	logic [CIDX_W-1:0] bidx_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q [MAX_CLUSTERS];
	logic [NCEN-1:0]   sum_vld_q;

	// Output register.
	logic                m_tvalid_q;
	logic [CIDX_W-1:0]   out_cidx_q;
	logic [DIDX_W-1:0]   out_didx_q;
	logic [COORD_W-1:0]  out_val_q;
	logic                out_drop_q;
	logic                out_last_q;

	// Memories.
	logic [COORD_W-1:0] pmem [1 << PADDR_W];
	logic [DIM_W-1:0]   lmem [MAX_POINTS];
	logic [CIDX_W-1:0]  amem [MAX_POINTS];
	logic [COORD_W-1:0] cmem [NCEN];
	logic [SUM_W-1:0]   smem [NCEN];

	logic [COORD_W-1:0] pm_rdata;
	logic [DIM_W-1:0]   lm_rdata;
	logic [CIDX_W-1:0]  am_rdata;
	logic [COORD_W-1:0] cm_rdata;
	logic [SUM_W-1:0]   sm_rdata;
	logic               sm_rvld_q;

	// Derived values.
	logic [DIM_W-1:0]   dim_eff;
	logic [DIDX_W-1:0]  dim_last;
	logic [CC_W-1:0]    k_eff;
	logic [CC_W-1:0]    k_val;
	logic [CIDX_W-1:0]  k_last;
	logic [PIDX_W-1:0]  n_last;
	logic               s_acc;
	logic               pt_end;
	logic               room;
	logic [PIDX_W-1:0]  rd_pidx;
	logic [COORD_W-1:0] pt_val;
	logic signed [COORD_W:0] diff;
	logic signed [SQ_W-1:0]  prod;
	logic [ACC_W-1:0]   acc_sum;
	logic [CADDR_W-1:0] sum_addr;
	logic [SUM_W-1:0]   sum_old;
	logic [SUM_W-1:0]   sum_new;
	logic [SUM_W-1:0]   sum_mag;
	logic [COORD_W-1:0] quot;
	logic [COORD_W-1:0] cen_new;
	logic               cluster_moved;
	logic               out_is_last;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	always_comb begin
		if (dimension_q == '0) begin
			dim_eff = DIM_W'(1);
		end else if (dimension_q > DIM_W'(MAX_DIM)) begin
			dim_eff = DIM_W'(MAX_DIM);
		end else begin
			dim_eff = dimension_q;
		end
		if (cluster_count_q == '0) begin
			k_eff = CC_W'(1);
		end else if (cluster_count_q > CC_W'(MAX_CLUSTERS)) begin
			k_eff = CC_W'(MAX_CLUSTERS);
		end else begin
			k_eff = cluster_count_q;
		end
		// Fewer points than clusters lowers k to the point count.
		if (pc_q < CNT_W'(k_eff)) begin
			k_val = CC_W'(pc_q);
		end else begin
			k_val = k_eff;
		end
	end

	assign dim_last = DIDX_W'(dim_eff - DIM_W'(1));
	assign k_last   = CIDX_W'(k_val - CC_W'(1));
	assign n_last   = PIDX_W'(pc_q - CNT_W'(1));

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign room     = (pc_q < CNT_W'(MAX_POINTS));
	assign pt_end   = (({1'b0, pos_q} + DIM_W'(1)) >= dim_eff) || s_tlast;

	// Coordinates past the stored length of a point read as zero.
	assign rd_pidx = (state_q == ST_INIT_RD) ? PIDX_W'(c_q) : p_q;
	assign pt_val  = ({1'b0, d_q} < lm_rdata) ? pm_rdata : '0;

	assign diff    = $signed({pt_val[COORD_W-1], pt_val}) -
	                 $signed({cm_rdata[COORD_W-1], cm_rdata});
	assign prod    = diff * diff;
	assign acc_sum = acc_q + ACC_W'(sq_q);

	assign sum_addr = (state_q == ST_U_RD) ? {c_q, d_q} : {bidx_q, d_q};
	assign sum_old  = sm_rvld_q ? sm_rdata : '0;
	assign sum_new  = sum_old + {{(SUM_W - COORD_W){pt_val[COORD_W-1]}}, pt_val};
	assign sum_mag  = sm_rdata[SUM_W-1] ? (~sm_rdata + SUM_W'(1)) : sm_rdata;

	assign quot    = div_rsp.quotient[COORD_W-1:0];
	assign cen_new = neg_q ? (~quot + COORD_W'(1)) : quot;

	assign cluster_moved = first_q ? (bidx_q != '0) : (bidx_q != am_rdata);
	assign out_is_last   = (c_q == k_last) && (d_q == dim_last);

	assign div_req.start    = (state_q == ST_U_DIV);
	assign div_req.dividend = sum_mag;
	assign div_req.divisor  = cnt_q[c_q];

	kce_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Point and point-length memories: written while loading, read by the sequencer.
	always_ff @(posedge clk) begin
		if (s_acc && room) begin
			pmem[{pc_q[PIDX_W-1:0], pos_q}] <= s_tdata;
			if (pt_end) begin
				lmem[pc_q[PIDX_W-1:0]] <= DIM_W'({1'b0, pos_q} + DIM_W'(1));
			end
		end
		if (state_q == ST_INIT_RD || state_q == ST_D_RD || state_q == ST_S_RD) begin
			pm_rdata <= pmem[{rd_pidx, d_q}];
			lm_rdata <= lmem[rd_pidx];
		end
	end

	// Assignment memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_ASG) begin
			amem[p_q] <= bidx_q;
		end
		if (state_q == ST_P_START) begin
			am_rdata <= amem[p_q];
		end
	end

	// Centroid memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT_WR) begin
			cmem[{c_q, d_q}] <= pt_val;
		end else if (state_q == ST_U_WAIT && div_rsp.done) begin
			cmem[{c_q, d_q}] <= cen_new;
		end
		if (state_q == ST_D_RD || state_q == ST_E_RD) begin
			cm_rdata <= cmem[{c_q, d_q}];
		end
	end

	// Sum memory; its valid flags stand in for clearing it each pass.
	always_ff @(posedge clk) begin
		if (state_q == ST_S_WR) begin
			smem[sum_addr] <= sum_new;
		end
		if (state_q == ST_S_RD || state_q == ST_U_RD) begin
			sm_rdata <= smem[sum_addr];
		end
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q   <= CLUSTER_COUNT_RST;
			iteration_limit_q <= ITERATION_LIMIT_RST;
			dimension_q       <= DIMENSION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLUSTER_COUNT:   cluster_count_q   <= cfg_data[CC_W-1:0];
				REG_ITERATION_LIMIT: iteration_limit_q <= cfg_data[IT_W-1:0];
				REG_DIMENSION:       dimension_q       <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Datapath registers of the shared unit.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_P_START: begin
				acc_q <= '0;
			end
			ST_D_MUL: begin
				sq_q <= SQ_W'(prod);
			end
			ST_D_ACC: begin
				if (d_q == dim_last) begin
					acc_q <= '0;
					// The lower centroid keeps a tie.
					if (c_q == '0 || acc_sum < best_q) begin
						best_q <= acc_sum;
						bidx_q <= c_q;
					end
				end else begin
					acc_q <= acc_sum;
				end
			end
			ST_U_DIV: begin
				neg_q <= sm_rdata[SUM_W-1];
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			pc_q       <= '0;
			pos_q      <= '0;
			ovf_q      <= 1'b0;
			p_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			it_q       <= '0;
			first_q    <= 1'b0;
			changed_q  <= 1'b0;
			sum_vld_q  <= '0;
			sm_rvld_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_drop_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_S_RD || state_q == ST_U_RD) begin
				sm_rvld_q <= sum_vld_q[sum_addr];
			end
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (room) begin
							if (pt_end) begin
								pc_q  <= pc_q + CNT_W'(1);
								pos_q <= '0;
							end else begin
								pos_q <= pos_q + DIDX_W'(1);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							c_q     <= '0;
							d_q     <= '0;
							state_q <= ST_INIT_RD;
						end
					end
				end
				ST_INIT_RD: begin
					state_q <= ST_INIT_WR;
				end
				ST_INIT_WR: begin
					if (d_q == DIDX_W'(MAX_DIM - 1)) begin
						d_q <= '0;
						if (c_q == k_last) begin
							c_q     <= '0;
							it_q    <= '0;
							first_q <= 1'b1;
							state_q <= (iteration_limit_q == '0) ? ST_E_RD : ST_IT_START;
						end else begin
							c_q     <= c_q + CIDX_W'(1);
							state_q <= ST_INIT_RD;
						end
					end else begin
						d_q     <= d_q + DIDX_W'(1);
						state_q <= ST_INIT_RD;
					end
				end
				ST_IT_START: begin
					sum_vld_q <= '0;
					changed_q <= 1'b0;
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						cnt_q[i] <= '0;
					end
					p_q     <= '0;
					state_q <= ST_P_START;
				end
				ST_P_START: begin
					c_q     <= '0;
					d_q     <= '0;
					state_q <= ST_D_RD;
				end
				ST_D_RD: begin
					state_q <= ST_D_MUL;
				end
				ST_D_MUL: begin
					state_q <= ST_D_ACC;
				end
				ST_D_ACC: begin
					if (d_q == dim_last) begin
						d_q <= '0;
						if (c_q == k_last) begin
							state_q <= ST_ASG;
						end else begin
							c_q     <= c_q + CIDX_W'(1);
							state_q <= ST_D_RD;
						end
					end else begin
						d_q     <= d_q + DIDX_W'(1);
						state_q <= ST_D_RD;
					end
				end
				ST_ASG: begin
					changed_q      <= changed_q | cluster_moved;
					cnt_q[bidx_q]  <= cnt_q[bidx_q] + CNT_W'(1);
					d_q            <= '0;
					state_q        <= ST_S_RD;
				end
				ST_S_RD: begin
					state_q <= ST_S_WR;
				end
				ST_S_WR: begin
					sum_vld_q[sum_addr] <= 1'b1;
					if (d_q == dim_last) begin
						d_q <= '0;
						if (p_q == n_last) begin
							c_q     <= '0;
							state_q <= ST_U_CHK;
						end else begin
							p_q     <= p_q + PIDX_W'(1);
							state_q <= ST_P_START;
						end
					end else begin
						d_q     <= d_q + DIDX_W'(1);
						state_q <= ST_S_RD;
					end
				end
				ST_U_CHK: begin
					d_q <= '0;
					// An empty cluster keeps its centroid.
					if (cnt_q[c_q] == '0) begin
						if (c_q == k_last) begin
							state_q <= ST_IT_END;
						end else begin
							c_q <= c_q + CIDX_W'(1);
						end
					end else begin
						state_q <= ST_U_RD;
					end
				end
				ST_U_RD: begin
					state_q <= ST_U_DIV;
				end
				ST_U_DIV: begin
					state_q <= ST_U_WAIT;
				end
				ST_U_WAIT: begin
					if (div_rsp.done) begin
						if (d_q == dim_last) begin
							d_q <= '0;
							if (c_q == k_last) begin
								state_q <= ST_IT_END;
							end else begin
								c_q     <= c_q + CIDX_W'(1);
								state_q <= ST_U_CHK;
							end
						end else begin
							d_q     <= d_q + DIDX_W'(1);
							state_q <= ST_U_RD;
						end
					end
				end
				ST_IT_END: begin
					first_q <= 1'b0;
					c_q     <= '0;
					d_q     <= '0;
					if (!changed_q || (it_q + IT_W'(1)) == iteration_limit_q) begin
						state_q <= ST_E_RD;
					end else begin
						it_q    <= it_q + IT_W'(1);
						state_q <= ST_IT_START;
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_LD;
				end
				ST_E_LD: begin
					m_tvalid_q <= 1'b1;
					out_last_q <= out_is_last;
					out_drop_q <= ovf_q;
					state_q    <= ST_E_OUT;
				end
				ST_E_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (out_last_q) begin
							pc_q    <= '0;
							pos_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							if (d_q == dim_last) begin
								d_q <= '0;
								c_q <= c_q + CIDX_W'(1);
							end else begin
								d_q <= d_q + DIDX_W'(1);
							end
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_E_LD) begin
			out_cidx_q <= c_q;
			out_didx_q <= d_q;
			out_val_q  <= cm_rdata;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_val_q, out_didx_q, out_cidx_q};
	assign m_tuser  = out_drop_q;
	assign m_tlast  = out_last_q;

`include "assert_macros.svh"
	`ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid), "input and output active together")
	`ASSERT_NEXT(a_back_to_load, m_tvalid && m_tready && m_tlast, s_tready,
		"engine not ready for a new set after the final word")
	`ASSERT_IMPLIES(a_div_done_wait, div_rsp.done, state_q == ST_U_WAIT,
		"divider result outside the wait state")
	`ASSERT_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy,
		"divider started while busy")
	`ASSERT_IMPLIES(a_best_in_range, state_q == ST_ASG, bidx_q <= k_last,
		"nearest centroid beyond the cluster count")

endmodule

### test/testbench.sv
// Self-checking testbench for the k-means clustering engine, with its own prediction of each set.
`timescale 1ns / 1ps

module testbench
	import kce_pkg::*;
();

	localparam int CYCLE_LIMIT  = 3000000;
	localparam int RANDOM_WORDS = 330;
	localparam int SETTLE       = 16;

	typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

	// One row of the directed table: either a register write or one input word.
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [4:0]  reg_val;
		logic [15:0] coord;
		bit          lastp;
		bit          typed;
		logic [15:0] typed_val;
	} row_t;

	// One expected result word.
	typedef struct {
		logic [1:0]  cluster;
		logic [3:0]  cidx;
		logic [15:0] value;
		bit          dropped;
		bit          last;
	} centroid_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [COORD_W-1:0]     s_tdata = '0;   // coord
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // cluster_index, coord_index, centroid_value
	logic                   m_tuser;        // dropped
	logic                   m_tlast;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	kmeans_cluster_engine dut (.*);

	always #1 clk = ~clk;

	// Own copy of the block's state and registers.
	logic signed [15:0] pts [MAX_POINTS*MAX_DIM];
	logic [1:0]         asg [MAX_POINTS];
	logic signed [15:0] cen [MAX_CLUSTERS*MAX_DIM];
	int unsigned        pcount, cpos;
	bit                 ovf;
	int unsigned        reg_cc = 4, reg_it = 10, reg_dim = 16;

	centroid_word_t centroid_q[$];
	int             errors = 0;
	int             cycles = 0;
	bit             idle_on = 1'b1;
	int             stall_left = 0;

	function automatic int unsigned eff_dim();
		if (reg_dim < 1) return 1;
		if (reg_dim > MAX_DIM) return MAX_DIM;
		return reg_dim;
	endfunction

	function automatic int unsigned eff_k();
		if (reg_cc < 1) return 1;
		if (reg_cc > MAX_CLUSTERS) return MAX_CLUSTERS;
		return reg_cc;
	endfunction

	function automatic longint unsigned dist2(int unsigned p, int unsigned c, int unsigned dim);
		longint unsigned acc;
		longint diff;
		acc = 0;
		for (int d = 0; d < dim; d++) begin
			diff = longint'(pts[p*MAX_DIM+d]) - longint'(cen[c*MAX_DIM+d]);
			acc += longint'(diff * diff);
		end
		return acc;
	endfunction

	// Lloyd passes over the stored set, leaving the final centroids in cen.
	function automatic void cluster_set(int unsigned n, int unsigned k, int unsigned dim);
		longint          sums [MAX_CLUSTERS*MAX_DIM];
		int unsigned     cnts [MAX_CLUSTERS];
		int unsigned     best;
		longint unsigned bestd, dd;
		bit              changed;
		for (int p = 0; p < MAX_POINTS; p++) asg[p] = '0;
		for (int c = 0; c < k; c++)
			for (int d = 0; d < MAX_DIM; d++) cen[c*MAX_DIM+d] = pts[c*MAX_DIM+d];
		for (int it = 0; it < reg_it; it++) begin
			changed = 1'b0;
			for (int i = 0; i < MAX_CLUSTERS*MAX_DIM; i++) sums[i] = 0;
			for (int c = 0; c < MAX_CLUSTERS; c++) cnts[c] = 0;
			for (int p = 0; p < n; p++) begin
				best = 0;
				bestd = dist2(p, 0, dim);
				for (int c = 1; c < k; c++) begin
					dd = dist2(p, c, dim);
					if (dd < bestd) begin
						bestd = dd;
						best = c;
					end
				end
				if (asg[p] != best[1:0]) begin
					asg[p] = best[1:0];
					changed = 1'b1;
				end
				for (int d = 0; d < dim; d++) sums[best*MAX_DIM+d] += pts[p*MAX_DIM+d];
				cnts[best]++;
			end
			// An empty cluster keeps its centroid; the division truncates toward zero.
			for (int c = 0; c < k; c++)
				if (cnts[c] != 0)
					for (int d = 0; d < dim; d++)
						cen[c*MAX_DIM+d] = 16'(sums[c*MAX_DIM+d] / longint'(cnts[c]));
			if (!changed) break;
		end
	endfunction

	// Takes one accepted word; on the end of a set it queues every centroid word.
	function automatic void predict_word(logic [15:0] coord, bit lastp);
		int unsigned    dim, pos, n, k;
		centroid_word_t w;
		dim = eff_dim();
		if (pcount < MAX_POINTS) begin
			pos = (cpos >= MAX_DIM) ? MAX_DIM - 1 : cpos;
			pts[pcount*MAX_DIM+pos] = coord;
			if (pos + 1 >= dim || lastp) begin
				for (int d = pos + 1; d < MAX_DIM; d++) pts[pcount*MAX_DIM+d] = '0;
				pcount++;
				cpos = 0;
			end else begin
				cpos = pos + 1;
			end
		end else begin
			ovf = 1'b1;
		end
		if (!lastp) return;
		n = pcount;
		k = eff_k();
		if (k > n) k = n;
		cluster_set(n, k, dim);
		for (int c = 0; c < k; c++)
			for (int d = 0; d < dim; d++) begin
				w.cluster = c[1:0];
				w.cidx = d[3:0];
				w.value = cen[c*MAX_DIM+d];
				w.dropped = ovf;
				w.last = (c + 1 == k) && (d + 1 == dim);
				centroid_q = {centroid_q, w};
			end
		pcount = 0;
		cpos = 0;
		ovf = 1'b0;
	endfunction

	// Offers one word, with an occasional gap before it, and waits for it to be taken.
	task automatic send_word(logic [15:0] coord, bit lastp, bit typed, logic [15:0] typed_val);
		int first;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= coord;
		s_tlast <= lastp;
		do @(posedge clk); while (!s_tready);
		first = centroid_q.size();
		predict_word(coord, lastp);
		// A value that can be read off directly replaces the predicted one.
		if (typed && centroid_q.size() > first) centroid_q[first].value = typed_val;
	endtask

	// Waits until every expected word has come out and the block has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (centroid_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CLUSTER_COUNT:   reg_cc = val & 5'h7;
			REG_ITERATION_LIMIT: reg_it = val & 5'hF;
			REG_DIMENSION:       reg_dim = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic row_t cfg_row(logic [1:0] idx, logic [4:0] val);
		row_t r;
		r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, coord: 0, lastp: 0, typed: 0,
			typed_val: 0};
		return r;
	endfunction

	function automatic row_t word_row(logic [15:0] coord, bit lastp, bit typed = 0,
			logic [15:0] tv = 0);
		row_t r;
		r = '{kind: ROW_WORD, reg_idx: 0, reg_val: 0, coord: coord, lastp: lastp, typed: typed,
			typed_val: tv};
		return r;
	endfunction

	// Receiver: stalls in short random bursts while idling is on, and checks every word taken.
	always @(posedge clk) begin
		centroid_word_t e;
		if (!idle_on || stall_left == 0) begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end else begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (centroid_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h tuser %b tlast %b",
					$realtime, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				e = centroid_q.pop_front();
				if (m_tdata[1:0] !== e.cluster || m_tdata[5:2] !== e.cidx ||
						m_tdata[21:6] !== e.value || m_tdata[23:22] !== 2'b00 ||
						m_tuser !== e.dropped || m_tlast !== e.last)
					begin
					$display("%0t: mismatch: expected c%0d d%0d v%h u%b l%b, actual c%0d d%0d v%h u%b l%b",
						$realtime, e.cluster, e.cidx, e.value, e.dropped, e.last,
						m_tdata[1:0], m_tdata[5:2], m_tdata[21:6], m_tuser, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL kmeans_cluster_engine");
			$finish;
		end
	end

	initial begin
		row_t        tab[$];
		int          sent, npts, dim, nlast, ctr, spread;
		bit          noise;
		logic [15:0] centre [4];
		logic [15:0] v;
		pcount = 0;
		cpos = 0;
		ovf = 1'b0;
		for (int i = 0; i < MAX_POINTS*MAX_DIM; i++) pts[i] = '0;
		for (int i = 0; i < MAX_CLUSTERS*MAX_DIM; i++) cen[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A single short point after reset is its own centroid.
		tab = {tab, word_row(16'h7FFF, 1, 1, 16'h7FFF)};
		tab = {tab, cfg_row(REG_DIMENSION, 5'd2)};
		tab = {tab, cfg_row(REG_CLUSTER_COUNT, 5'd2)};
		tab = {tab, word_row(16'h8000, 0)};
		tab = {tab, word_row(16'h0001, 0)};
		tab = {tab, word_row(16'h7FFF, 0)};
		tab = {tab, word_row(16'h8000, 1)};
		// No passes: the first point stands as the centroid.
		tab = {tab, cfg_row(REG_ITERATION_LIMIT, 5'd0)};
		tab = {tab, word_row(16'h1234, 0)};
		tab = {tab, word_row(16'h5678, 1, 1, 16'h1234)};
		// Zero in both sizes acts as one.
		tab = {tab, cfg_row(REG_CLUSTER_COUNT, 5'd0)};
		tab = {tab, cfg_row(REG_DIMENSION, 5'd0)};
		tab = {tab, cfg_row(REG_ITERATION_LIMIT, 5'd15)};
		tab = {tab, word_row(16'h0005, 0)};
		tab = {tab, word_row(16'h0007, 0)};
		tab = {tab, word_row(16'h8000, 0)};
		tab = {tab, word_row(16'hFFFF, 1)};
		// Sizes above the maximum are clamped; one short point gives k of one.
		tab = {tab, cfg_row(REG_CLUSTER_COUNT, 5'd7)};
		tab = {tab, cfg_row(REG_DIMENSION, 5'd31)};
		tab = {tab, word_row(16'h00FF, 0)};
		tab = {tab, word_row(16'hFF00, 0)};
		tab = {tab, word_row(16'h0000, 1)};
		// Identical points tie; the lower centroid takes both and the other stays empty.
		tab = {tab, cfg_row(REG_CLUSTER_COUNT, 5'd2)};
		tab = {tab, cfg_row(REG_DIMENSION, 5'd1)};
		tab = {tab, cfg_row(REG_ITERATION_LIMIT, 5'd3)};
		tab = {tab, word_row(16'h0005, 0)};
		tab = {tab, word_row(16'h0005, 1)};
		// Mixed signs with truncation toward zero.
		tab = {tab, cfg_row(REG_CLUSTER_COUNT, 5'd4)};
		tab = {tab, word_row(16'hFFFF, 0)};
		tab = {tab, word_row(16'hFFFE, 0)};
		tab = {tab, word_row(16'h0003, 0)};
		tab = {tab, word_row(16'h0004, 0)};
		tab = {tab, word_row(16'h7000, 1)};

		foreach (tab[i]) begin
			if (tab[i].kind == ROW_CFG) begin
				drain();
				write_reg(tab[i].reg_idx, tab[i].reg_val);
			end else begin
				send_word(tab[i].coord, tab[i].lastp, tab[i].typed, tab[i].typed_val);
			end
		end

		// Random sets, mostly clustered content around a few centres, some pure noise.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			drain();
			if (sent > RANDOM_WORDS * 4 / 5) idle_on = 1'b0;
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_CLUSTER_COUNT, ($urandom_range(0, 7) == 0) ?
					5'($urandom_range(0, 7)) : 5'($urandom_range(1, 4)));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_ITERATION_LIMIT, ($urandom_range(0, 9) == 0) ?
					5'd0 : 5'($urandom_range(1, 15)));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_DIMENSION, ($urandom_range(0, 4) == 0) ?
					5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4)));
			dim = eff_dim();
			npts = (dim > 8) ? $urandom_range(1, 4) : $urandom_range(1, 10);
			// The final point is sometimes cut short by the end of the set.
			nlast = ($urandom_range(0, 3) == 0) ? $urandom_range(1, dim) : dim;
			noise = ($urandom_range(0, 4) == 0);
			spread = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h00FF;
			for (int c = 0; c < 4; c++) centre[c] = 16'($urandom);
			for (int p = 0; p < npts; p++) begin
				ctr = $urandom_range(0, 3);
				for (int d = 0; d < ((p == npts - 1) ? nlast : dim); d++) begin
					v = noise ? 16'($urandom) : centre[ctr] + 16'($urandom & spread);
					send_word(v, (p == npts - 1) && (d == nlast - 1), 0, 0);
					sent++;
				end
			end
		end

		drain();
		repeat (4 * SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("PASS kmeans_cluster_engine");
		end else begin
			$display("FAIL kmeans_cluster_engine");
		end
		$finish;
	end

endmodule

### kmeans_cluster_engine.f
+incdir+sv
sv/kce_pkg.sv
sv/kce_divider.sv
sv/kmeans_cluster_engine.sv
test/testbench.sv
